FILE: sv/keepalive_path_liveness_monitor_top_assert.svh
// assertion macros for the keepalive path liveness monitor
`ifndef KEEPALIVE_PATH_LIVENESS_MONITOR_TOP_ASSERT_SVH
`define KEEPALIVE_PATH_LIVENESS_MONITOR_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define KPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define KPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/kpm_pkg.sv
// types and constants shared by the keepalive path liveness monitor
package kpm_pkg;

  localparam int CFG_W     = 32;
  localparam int MAX_TRACK = 8;

  localparam logic [2:0] REG_BEAT_INTERVAL = 3'd0;
  localparam logic [2:0] REG_DOWN_TIMEOUT  = 3'd1;
  localparam logic [2:0] REG_PATHS_IN_USE  = 3'd2;
  localparam logic [2:0] REG_BEAT_CODE     = 3'd3;
  localparam logic [2:0] REG_ACK_CODE      = 3'd4;

  localparam logic [2:0] KIND_NOTHING   = 3'd0;
  localparam logic [2:0] KIND_BEAT      = 3'd1;
  localparam logic [2:0] KIND_ACK_SENT  = 3'd2;
  localparam logic [2:0] KIND_PATH      = 3'd3;
  localparam logic [2:0] KIND_ACK_SEEN  = 3'd4;
  localparam logic [2:0] KIND_MALFORMED = 3'd5;
  localparam logic [2:0] KIND_IGNORED   = 3'd6;

  localparam logic [1:0] LINK_UP   = 2'd0;
  localparam logic [1:0] LINK_WEAK = 2'd1;
  localparam logic [1:0] LINK_LOST = 2'd2;

  localparam logic [15:0] MIN_CTRL_LEN = 16'd25;
  localparam logic [15:0] MIN_BEAT_LEN = 16'd41;

  typedef struct packed {
    logic        func;
    logic [63:0] now_time;
    logic        locked;
    logic [15:0] pkt_length;
    logic [7:0]  pkt_opcode;
    logic [63:0] pkt_stamp;
  } kpm_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seq_out;
    logic [63:0] stamp_out;
    logic [2:0]  path_number;
    logic [1:0]  new_path_state;
    logic        last;
  } kpm_out_t;

  typedef struct packed {
    logic [31:0] beat_interval;
    logic [31:0] down_timeout;
    logic [3:0]  paths_in_use;
    logic [7:0]  beat_code;
    logic [7:0]  ack_code;
  } kpm_cfg_t;

  typedef struct packed {
    logic capture;
    logic beat_diff;
    logic walk_diff;
    logic emit_item;
    logic emit_beat;
    logic idx_clear;
    logic idx_inc;
    logic push_deg;
    logic push_down;
    logic flush;
  } kpm_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic locked;
    logic beat_due;
    logic idx_done;
    logic deg_hit;
    logic down_hit;
    logic out_free;
    logic pend_valid;
  } kpm_stat_t;

endpackage

FILE: sv/kpm_ctrl.sv
// controller state machine for the keepalive path liveness monitor
module kpm_ctrl import kpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  kpm_stat_t stat,
  output kpm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_BEAT  = 3'd2;
  localparam logic [2:0] S_WSUB  = 3'd3;
  localparam logic [2:0] S_WCHK  = 3'd4;
  localparam logic [2:0] S_WDOWN = 3'd5;
  localparam logic [2:0] S_WEND  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       can_push;

  // a push moves any held path result to the output register
  assign can_push   = !stat.pend_valid || stat.out_free;
  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.is_tick && stat.locked) begin
          cmd.beat_diff = 1'b1;
          state_next    = S_BEAT;
        end else if (stat.out_free) begin
          cmd.emit_item = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_BEAT: begin
        if (!stat.beat_due) begin
          cmd.idx_clear = 1'b1;
          state_next    = S_WSUB;
        end else if (stat.out_free) begin
          cmd.emit_beat = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_WSUB: begin
        if (stat.idx_done) begin
          state_next = S_WEND;
        end else begin
          cmd.walk_diff = 1'b1;
          state_next    = S_WCHK;
        end
      end
      S_WCHK: begin
        if (stat.deg_hit) begin
          if (can_push) begin
            cmd.push_deg = 1'b1;
            if (stat.down_hit) begin
              state_next = S_WDOWN;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next  = S_WSUB;
            end
          end
        end else if (stat.down_hit) begin
          if (can_push) begin
            cmd.push_down = 1'b1;
            cmd.idx_inc   = 1'b1;
            state_next    = S_WSUB;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_WSUB;
        end
      end
      S_WDOWN: begin
        if (can_push) begin
          cmd.push_down = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_next    = S_WSUB;
        end
      end
      S_WEND: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/kpm_datapath.sv
// datapath: item register, timers, path table, held result and output register
module kpm_datapath import kpm_pkg::*; #(
  parameter int MAX_PATHS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  kpm_cfg_t  cfg,
  input  kpm_in_t   item,
  input  kpm_cmd_t  cmd,
  output kpm_stat_t stat,
  output logic      result_valid,
  input  logic      result_stall,
  output kpm_out_t  result
);

  localparam int NP = (MAX_PATHS < MAX_TRACK) ? MAX_PATHS : MAX_TRACK;
  localparam int CW = $clog2(NP + 1);
  localparam int IW = (NP > 1) ? $clog2(NP) : 1;

  kpm_in_t     cur;
  logic [33:0] degrade;
  logic [63:0] diff;
  logic [31:0] seq_count;
  logic [63:0] last_beat_time;
  logic [63:0] act [NP];
  logic [1:0]  cond [NP];
  logic [CW-1:0] idx;
  logic [IW-1:0] sel;
  logic [3:0]  n_track;

  logic        pend_valid;
  logic [2:0]  pend_path;
  logic [1:0]  pend_state;

  logic        out_free;
  logic        out_load;
  kpm_out_t    out_next;
  logic [2:0]  pkt_kind;
  logic        do_push;
  logic [1:0]  push_state;
  logic        refresh;
  logic        seq_inc;

  assign sel     = idx[IW-1:0];
  assign n_track = (cfg.paths_in_use > 4'(NP)) ? 4'(NP) : cfg.paths_in_use;

  assign out_free = !result_valid || !result_stall;

  // classify the word that does not need a path walk
  always_comb begin
    pkt_kind = KIND_NOTHING;
    if (cur.func) begin
      if (cur.pkt_length < MIN_CTRL_LEN) begin
        pkt_kind = KIND_IGNORED;
      end else if (cur.pkt_opcode == cfg.beat_code) begin
        pkt_kind = (cur.pkt_length < MIN_BEAT_LEN) ? KIND_MALFORMED : KIND_ACK_SENT;
      end else if (cur.pkt_opcode == cfg.ack_code) begin
        pkt_kind = KIND_ACK_SEEN;
      end else begin
        pkt_kind = KIND_IGNORED;
      end
    end
  end

  assign do_push    = cmd.push_deg || cmd.push_down;
  assign push_state = cmd.push_deg ? LINK_WEAK : LINK_LOST;
  assign refresh    = cmd.emit_item &&
                      (pkt_kind == KIND_ACK_SENT || pkt_kind == KIND_ACK_SEEN);
  assign seq_inc    = cmd.emit_beat || (cmd.emit_item && pkt_kind == KIND_ACK_SENT);

  assign stat.is_tick    = !cur.func;
  assign stat.locked     = cur.locked;
  assign stat.beat_due   = diff >= 64'(cfg.beat_interval);
  assign stat.idx_done   = 4'(idx) >= n_track;
  assign stat.deg_hit    = (cond[sel] == LINK_UP) && (diff > 64'(degrade));
  assign stat.down_hit   = (cond[sel] == LINK_WEAK || stat.deg_hit) &&
                           (diff > 64'(cfg.down_timeout));
  assign stat.out_free   = out_free;
  assign stat.pend_valid = pend_valid;

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (cmd.emit_item) begin
      out_load      = 1'b1;
      out_next.kind = pkt_kind;
      if (pkt_kind == KIND_ACK_SENT) begin
        out_next.seq_out   = seq_count;
        out_next.stamp_out = cur.pkt_stamp;
      end
      out_next.last = 1'b1;
    end else if (cmd.emit_beat) begin
      out_load           = 1'b1;
      out_next.kind      = KIND_BEAT;
      out_next.seq_out   = seq_count;
      out_next.stamp_out = cur.now_time;
      out_next.last      = 1'b1;
    end else if (do_push && pend_valid) begin
      out_load                = 1'b1;
      out_next.kind           = KIND_PATH;
      out_next.path_number    = pend_path;
      out_next.new_path_state = pend_state;
    end else if (cmd.flush) begin
      out_load = 1'b1;
      if (pend_valid) begin
        out_next.kind           = KIND_PATH;
        out_next.path_number    = pend_path;
        out_next.new_path_state = pend_state;
      end
      out_next.last = 1'b1;
    end
  end

  // item register, degrade threshold, shared subtractor, held path result and output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur     <= item;
      degrade <= {2'b00, cfg.beat_interval} + {1'b0, cfg.beat_interval, 1'b0};
    end
    if (cmd.beat_diff) begin
      diff <= cur.now_time - last_beat_time;
    end else if (cmd.walk_diff) begin
      diff <= cur.now_time - act[sel];
    end
    if (do_push) begin
      pend_path  <= 3'(sel);
      pend_state <= push_state;
    end
    if (out_load) begin
      result <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_count      <= '0;
      last_beat_time <= '0;
      idx            <= '0;
      pend_valid     <= 1'b0;
      result_valid   <= 1'b0;
      for (int i = 0; i < NP; i++) begin
        act[i]  <= '0;
        cond[i] <= LINK_UP;
      end
    end else begin
      if (seq_inc) begin
        seq_count <= seq_count + 32'd1;
      end
      if (cmd.emit_beat) begin
        last_beat_time <= cur.now_time;
      end
      if (refresh) begin
        for (int i = 0; i < NP; i++) begin
          if (4'(i) < n_track) begin
            act[i] <= cur.now_time;
          end
        end
      end
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (do_push) begin
        cond[sel] <= push_state;
      end
      if (cmd.idx_clear || cmd.flush) begin
        pend_valid <= 1'b0;
      end else if (do_push) begin
        pend_valid <= 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/keepalive_path_liveness_monitor_top.sv
// top level: configuration registers, controller and datapath
// one word in flight at a time; a word is taken the cycle after its last result is registered
// packet or unlocked tick: item register, then result registered from the load state; beat sent: load, then beat state
// path walk: a subtract and a check state per tracked path, plus a down state for each path that drops straight
// from active to down (tracked paths at most 8); output stalls can hold any of these
// synchronous reset: registers to defaults, sequence and timers to zero, paths active
module keepalive_path_liveness_monitor_top import kpm_pkg::*; #(
  parameter int MAX_PATHS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  kpm_in_t          item,
  output logic             result_valid,
  input  logic             result_stall,
  output kpm_out_t         result,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  kpm_cfg_t  cfg;
  kpm_cmd_t  cmd;
  kpm_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.beat_interval <= 32'd1000;
      cfg.down_timeout  <= 32'd10000;
      cfg.paths_in_use  <= 4'd1;
      cfg.beat_code     <= 8'd1;
      cfg.ack_code      <= 8'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BEAT_INTERVAL: cfg.beat_interval <= cfg_data;
        REG_DOWN_TIMEOUT:  cfg.down_timeout  <= cfg_data;
        REG_PATHS_IN_USE:  cfg.paths_in_use  <= cfg_data[3:0];
        REG_BEAT_CODE:     cfg.beat_code     <= cfg_data[7:0];
        REG_ACK_CODE:      cfg.ack_code      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  kpm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  kpm_datapath #(
    .MAX_PATHS (MAX_PATHS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: sv/kpm_checker.sv
// port-level checks for the keepalive path liveness monitor, bound to the top level
`include "keepalive_path_liveness_monitor_top_assert.svh"

module kpm_checker import kpm_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     item_valid,
  input logic     item_stall,
  input logic     result_valid,
  input logic     result_stall,
  input kpm_out_t result
);

  // a held result word must not move
  `KPM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result word changed while stalled")
  // one word at a time: the block is busy right after taking one
  `KPM_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "word taken while previous word still in work")
  // a path change reports degraded or down only
  `KPM_ASSERT_IMP(a_path_state, result_valid && result.kind == KIND_PATH, result.new_path_state == LINK_WEAK || result.new_path_state == LINK_LOST, "path change with bad state")
  // only path changes can be followed by more results of the same word
  `KPM_ASSERT_IMP(a_single_last, result_valid && result.kind != KIND_PATH, result.last && result.path_number == 3'd0 && result.new_path_state == LINK_UP, "non-path result not final or carries path fields")

endmodule

bind keepalive_path_liveness_monitor_top kpm_checker u_kpm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
